/* design/dsv_pkg.sv */
package dsv_pkg;

    localparam logic [7:0] SLASH_CODE      = 8'd47;
    localparam logic [7:0] DIGIT_LOW_CODE  = 8'd48;
    localparam logic [7:0] DIGIT_LIMIT     = 8'd58;

    localparam logic [1:0] FIELD_DAY       = 2'd0;
    localparam logic [1:0] FIELD_MONTH     = 2'd1;
    localparam logic [1:0] FIELD_YEAR      = 2'd2;

    localparam logic [2:0] SHORT_FIELD_MAX = 3'd2;
    localparam logic [2:0] YEAR_FIELD_MAX  = 3'd4;
    localparam logic [2:0] YEAR_SHORT_LEN  = 3'd2;

    localparam logic [6:0] MONTH_MAX       = 7'd12;
    localparam logic [6:0] MONTH_FEB       = 7'd2;
    localparam logic [6:0] MONTH_APR       = 7'd4;
    localparam logic [6:0] MONTH_JUN       = 7'd6;
    localparam logic [6:0] MONTH_SEP       = 7'd9;
    localparam logic [6:0] MONTH_NOV       = 7'd11;
    localparam logic [6:0] DAY_MAX         = 7'd31;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic       is_digit;
        logic       is_slash;
        logic [3:0] digit;
        logic       last;
    } dsv_item_t;

    function automatic logic [6:0] month_length(input logic [6:0] month, input logic leap);
        logic [6:0] len;
        case (month)
            MONTH_FEB: len = leap ? 7'd29 : 7'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 7'd30;
            default: len = DAY_MAX;
        endcase
        return len;
    endfunction

endpackage

/* design/dsv_front.sv */
module dsv_front (
    input  logic             char_valid,
    output logic             char_ready,
    input  logic [7:0]       char_code,
    input  logic             last_char,
    output logic             push_valid,
    input  logic             push_ready,
    output dsv_pkg::dsv_item_t push_item
);
    import dsv_pkg::*;

    logic [7:0] offset;

    assign offset     = char_code - DIGIT_LOW_CODE;
    assign char_ready = push_ready;
    assign push_valid = char_valid;

    always_comb
    begin
        push_item.is_slash = (char_code == SLASH_CODE);
        push_item.is_digit = (char_code >= DIGIT_LOW_CODE) && (char_code < DIGIT_LIMIT);
        push_item.digit    = offset[3:0];
        push_item.last     = last_char;
    end
endmodule

/* design/dsv_queue.sv */
module dsv_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  dsv_pkg::dsv_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output dsv_pkg::dsv_item_t pop_item
);
    import dsv_pkg::*;

    dsv_item_t           store_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = store_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end
endmodule

/* design/dsv_back.sv */
module dsv_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  dsv_pkg::dsv_item_t pop_item,
    output logic               result_valid,
    input  logic               result_ready,
    output logic               date_valid,
    output logic [6:0]         day_value,
    output logic [6:0]         month_value,
    output logic [13:0]        year_value
);
    import dsv_pkg::*;

    logic [1:0]  pos_reg, pos_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  month_reg, month_next;
    logic [13:0] year_reg, year_next;
    logic        err_reg, err_next;
    logic [6:0]  upper_reg, upper_next;
    logic [3:0]  tens_reg, tens_next;
    logic [3:0]  ones_reg, ones_next;

    logic        out_valid_reg, out_valid_next;
    logic        out_ok_reg;
    logic [6:0]  out_day_reg;
    logic [6:0]  out_month_reg;
    logic [13:0] out_year_reg;

    logic        take;
    logic [2:0]  limit;
    logic [10:0] day_x10, month_x10, upper_x10;
    logic [17:0] year_x10;
    logic        leap;
    logic        ok;

    assign pop_ready = !pop_item.last || !out_valid_reg || result_ready;
    assign take      = pop_valid && pop_ready;
    assign limit     = (pos_reg == FIELD_YEAR) ? YEAR_FIELD_MAX : SHORT_FIELD_MAX;

    assign day_x10   = ({4'b0, day_reg} << 3) + ({4'b0, day_reg} << 1)
                     + {7'b0, pop_item.digit};
    assign month_x10 = ({4'b0, month_reg} << 3) + ({4'b0, month_reg} << 1)
                     + {7'b0, pop_item.digit};
    assign year_x10  = ({4'b0, year_reg} << 3) + ({4'b0, year_reg} << 1)
                     + {14'b0, pop_item.digit};
    assign upper_x10 = ({4'b0, upper_reg} << 3) + ({4'b0, upper_reg} << 1)
                     + {7'b0, tens_reg};

    always_comb
    begin
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        err_next   = err_reg;
        upper_next = upper_reg;
        tens_next  = tens_reg;
        ones_next  = ones_reg;
        if (!err_reg)
        begin
            if (pop_item.is_slash)
            begin
                if (pos_reg == FIELD_YEAR || cnt_reg == 3'd0 || cnt_reg > SHORT_FIELD_MAX)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + 2'd1;
                    cnt_next = 3'd0;
                end
            end
            else if (!pop_item.is_digit)
            begin
                err_next = 1'b1;
            end
            else if (cnt_reg >= limit)
            begin
                err_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 3'd1;
                case (pos_reg)
                    FIELD_DAY:   day_next = day_x10[6:0];
                    FIELD_MONTH: month_next = month_x10[6:0];
                    default:
                    begin
                        year_next  = year_x10[13:0];
                        upper_next = upper_x10[6:0];
                        tens_next  = ones_reg;
                        ones_next  = pop_item.digit;
                    end
                endcase
            end
        end
    end

    // leap test from the binary year and the decimal digits: low two digits and the leading part
    assign leap = (year_next[1:0] == 2'b00)
               && ((tens_next != 4'd0) || (ones_next != 4'd0) || (upper_next[1:0] == 2'b00));

    assign ok = !err_next && (pos_next == FIELD_YEAR)
             && (cnt_next == YEAR_SHORT_LEN || cnt_next == YEAR_FIELD_MAX)
             && (month_next >= 7'd1) && (month_next <= MONTH_MAX)
             && (day_next >= 7'd1)
             && (day_next <= month_length(month_next, leap));

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (take && pop_item.last)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= FIELD_DAY;
            cnt_reg       <= '0;
            day_reg       <= '0;
            month_reg     <= '0;
            year_reg      <= '0;
            err_reg       <= 1'b0;
            upper_reg     <= '0;
            tens_reg      <= '0;
            ones_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                if (pop_item.last)
                begin
                    pos_reg   <= FIELD_DAY;
                    cnt_reg   <= '0;
                    day_reg   <= '0;
                    month_reg <= '0;
                    year_reg  <= '0;
                    err_reg   <= 1'b0;
                    upper_reg <= '0;
                    tens_reg  <= '0;
                    ones_reg  <= '0;
                end
                else
                begin
                    pos_reg   <= pos_next;
                    cnt_reg   <= cnt_next;
                    day_reg   <= day_next;
                    month_reg <= month_next;
                    year_reg  <= year_next;
                    err_reg   <= err_next;
                    upper_reg <= upper_next;
                    tens_reg  <= tens_next;
                    ones_reg  <= ones_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && pop_item.last)
        begin
            out_ok_reg    <= ok;
            out_day_reg   <= day_next;
            out_month_reg <= month_next;
            out_year_reg  <= year_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign date_valid   = out_ok_reg;
    assign day_value    = out_day_reg;
    assign month_value  = out_month_reg;
    assign year_value   = out_year_reg;
endmodule

/* design/date_string_validator.sv */
// Date string checker for the dd/mm/yyyy form. Characters enter one per transaction on the
// char channel, with last_char set on the final one; every character, including the last,
// can be taken once per clock cycle. A front stage classifies each character and a two-entry
// queue hands it to the parser, which keeps the field and digit state and produces one result
// transaction per string via an output register loaded as the parser takes its last character.
// date_valid is set for a string of digits and two slashes with a one- or two-digit day and
// month and a two- or four-digit year (used as written) that names an existing Gregorian date;
// otherwise day, month and year carry the partially parsed values. The parser stalls only
// when a result is still waiting in the output register and another string ends.
module date_string_validator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_ready,
    input  logic [7:0]  char_code,
    input  logic        last_char,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        date_valid,
    output logic [6:0]  day_value,
    output logic [6:0]  month_value,
    output logic [13:0] year_value
);
    import dsv_pkg::*;

    logic      push_valid, push_ready;
    logic      pop_valid, pop_ready;
    dsv_item_t push_item, pop_item;

    dsv_front u_front (
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_code  (char_code),
        .last_char  (last_char),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    dsv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    dsv_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_item     (pop_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .date_valid   (date_valid),
        .day_value    (day_value),
        .month_value  (month_value),
        .year_value   (year_value)
    );
endmodule
